FILE: rtl/tcfp_pkg.sv
// Shared types, constants and helpers for the tagged command frame parser.
// Used by every module under rtl/.
`default_nettype none

package tcfp_pkg;

	localparam int FRAME_CAPACITY = 32;
	localparam int POS_W          = $clog2(FRAME_CAPACITY + 1);

	localparam int BYTE_W   = 8;
	localparam int LEN_W    = 6;
	localparam int CODE_W   = 3;
	localparam int REPLY_W  = 2;
	localparam int CFG_IDX_W = 2;
	localparam int OUT_W    = 32;

	localparam logic [BYTE_W-1:0] ASCII_ZERO = 8'd48;

	localparam logic [CFG_IDX_W-1:0] REG_START_MARKER   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_END_MARKER     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COMMAND_MARKER = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PARAM_SEP      = 2'd3;

	localparam logic [BYTE_W-1:0] RST_START_MARKER   = 8'd60;
	localparam logic [BYTE_W-1:0] RST_END_MARKER     = 8'd62;
	localparam logic [BYTE_W-1:0] RST_COMMAND_MARKER = 8'd33;
	localparam logic [BYTE_W-1:0] RST_PARAM_SEP      = 8'd59;

	localparam logic [CODE_W-1:0] CMD_HI      = 3'd0;
	localparam logic [CODE_W-1:0] CMD_BY      = 3'd1;
	localparam logic [CODE_W-1:0] CMD_OK      = 3'd2;
	localparam logic [CODE_W-1:0] CMD_PV      = 3'd3;
	localparam logic [CODE_W-1:0] CMD_UNKNOWN = 3'd4;

	localparam logic [REPLY_W-1:0] REPLY_NONE = 2'd0;
	localparam logic [REPLY_W-1:0] REPLY_HI   = 2'd1;
	localparam logic [REPLY_W-1:0] REPLY_BYE  = 2'd2;

	typedef struct packed {
		logic [BYTE_W-1:0] start_marker;
		logic [BYTE_W-1:0] end_marker;
		logic [BYTE_W-1:0] command_marker;
		logic [BYTE_W-1:0] param_separator;
	} cfg_t;

	typedef struct packed {
		logic [REPLY_W-1:0] reply_code;
		logic [BYTE_W-1:0]  first_param;
		logic [LEN_W-1:0]   param_count;
		logic [CODE_W-1:0]  command_code;
		logic               is_command;
		logic               overflowed;
		logic [LEN_W-1:0]   frame_length;
	} result_t;

	function automatic logic [LEN_W-1:0] to_len(input logic [POS_W-1:0] x);
		logic [POS_W+LEN_W-1:0] ext;
		ext = {{LEN_W{1'b0}}, x};
		return ext[LEN_W-1:0];
	endfunction

	function automatic logic [CODE_W-1:0] lookup_cmd(
		input logic [BYTE_W-1:0] l1,
		input logic [BYTE_W-1:0] l2
	);
		logic [CODE_W-1:0] code;
		code = CMD_UNKNOWN;
		if (l1 == 8'h48 && l2 == 8'h49) code = CMD_HI;
		else if (l1 == 8'h42 && l2 == 8'h59) code = CMD_BY;
		else if (l1 == 8'h4F && l2 == 8'h4B) code = CMD_OK;
		else if (l1 == 8'h50 && l2 == 8'h56) code = CMD_PV;
		return code;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/tagged_command_frame_parser.sv
// Top level of the tagged command frame parser: stream ports, config port,
// result register. Depends on tcfp_pkg, tcfp_cfg_regs and tcfp_frame.
`default_nettype none

// One received byte per item, one item per cycle sustained. Each byte is
// registered, checked against the marker registers and folded into the
// frame state; an end marker inside a frame, once it sits in the input byte
// register, loads one result into the output register, which offers it. The
// input keeps accepting while a result waits, and stalls only when a second
// result is due before the first has been taken. Bytes before a start
// marker, repeated start markers and body bytes beyond FRAME_CAPACITY
// produce no result. Configuration writes are always ready and should be
// made only while no frame byte is in flight.
module tagged_command_frame_parser
	import tcfp_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [BYTE_W-1:0]    s_tdata,   // [7:0] rx_byte
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	// [5:0] frame_length, [6] overflowed, [7] is_command, [10:8] command_code,
	// [16:11] param_count, [24:17] first_param, [26:25] reply_code, rest 0
	output logic [OUT_W-1:0]          m_tdata,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [BYTE_W-1:0]    cfg_data
);

	cfg_t    cfg;
	result_t res;
	result_t res_q;
	logic    m_valid_q;
	logic    busy;
	logic    emit;
	logic    adv;
	logic    load;

	assign cfg_ready = 1'b1;

	tcfp_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	assign adv      = !emit || !m_valid_q || m_tready;
	assign s_tready = !busy || adv;
	assign load     = s_tvalid && s_tready;

	tcfp_frame u_frame (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.load    (load),
		.rx_byte (s_tdata),
		.adv     (adv),
		.busy    (busy),
		.emit    (emit),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (emit && adv) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit && adv) begin
			res_q <= res;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {{(OUT_W - $bits(result_t)){1'b0}}, res_q};

endmodule

`default_nettype wire

FILE: rtl/tcfp_cfg_regs.sv
// Configuration registers of the frame parser: marker and separator bytes.
// Depends on tcfp_pkg.
`default_nettype none

module tcfp_cfg_regs
	import tcfp_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 wr_en,
	input  wire logic [CFG_IDX_W-1:0] wr_index,
	input  wire logic [BYTE_W-1:0]    wr_data,
	output cfg_t                      cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_marker    <= RST_START_MARKER;
			cfg_q.end_marker      <= RST_END_MARKER;
			cfg_q.command_marker  <= RST_COMMAND_MARKER;
			cfg_q.param_separator <= RST_PARAM_SEP;
		end else if (wr_en) begin
			case (wr_index)
				REG_START_MARKER:   cfg_q.start_marker    <= wr_data;
				REG_END_MARKER:     cfg_q.end_marker      <= wr_data;
				REG_COMMAND_MARKER: cfg_q.command_marker  <= wr_data;
				REG_PARAM_SEP:      cfg_q.param_separator <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

FILE: rtl/tcfp_frame.sv
// Input byte register, frame state and per-byte update of the parser.
// Depends on tcfp_pkg; result goes to the output register in the top level.
`default_nettype none

module tcfp_frame
	import tcfp_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cfg_t              cfg,
	input  wire logic              load,
	input  wire logic [BYTE_W-1:0] rx_byte,
	input  wire logic              adv,
	output logic                   busy,
	output logic                   emit,
	output result_t                res
);

	logic              v_s1;
	logic [BYTE_W-1:0] byte_s1;

	logic              in_frame_q;
	logic [POS_W-1:0]  pos_q;
	logic [BYTE_W-1:0] letter1_q;
	logic [BYTE_W-1:0] letter2_q;
	logic              marker_q;
	logic [BYTE_W-1:0] acc_q;
	logic [POS_W-1:0]  sep_q;
	logic              ovf_q;

	logic              is_start;
	logic              is_end;
	logic              step;
	logic [BYTE_W-1:0] digit;
	logic [BYTE_W-1:0] acc_next;
	logic [CODE_W-1:0] code;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (load) begin
			v_s1 <= 1'b1;
		end else if (adv) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_s1 <= rx_byte;
		end
	end

	assign busy     = v_s1;
	assign is_start = (byte_s1 == cfg.start_marker);
	assign is_end   = (byte_s1 == cfg.end_marker);
	assign step     = v_s1 && adv;
	assign digit    = byte_s1 - ASCII_ZERO;
	assign acc_next = {acc_q[4:0], 3'b000} + {acc_q[6:0], 1'b0} + digit;
	assign emit     = v_s1 && in_frame_q && !is_start && is_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			pos_q      <= '0;
			letter1_q  <= '0;
			letter2_q  <= '0;
			marker_q   <= 1'b0;
			acc_q      <= '0;
			sep_q      <= '0;
			ovf_q      <= 1'b0;
		end else if (step) begin
			if (!in_frame_q) begin
				if (is_start) begin
					in_frame_q <= 1'b1;
					pos_q      <= '0;
					letter1_q  <= '0;
					letter2_q  <= '0;
					marker_q   <= 1'b0;
					acc_q      <= '0;
					sep_q      <= '0;
					ovf_q      <= 1'b0;
				end
			end else if (is_start) begin
				// repeated start inside a frame is ignored
			end else if (is_end) begin
				in_frame_q <= 1'b0;
			end else if (pos_q >= POS_W'(FRAME_CAPACITY)) begin
				ovf_q <= 1'b1;
			end else begin
				if (pos_q == POS_W'(0)) begin
					letter1_q <= byte_s1;
				end else if (pos_q == POS_W'(1)) begin
					letter2_q <= byte_s1;
				end else if (pos_q == POS_W'(2)) begin
					marker_q <= (byte_s1 == cfg.command_marker);
				end else if (pos_q <= POS_W'(5)) begin
					acc_q <= acc_next;
				end
				if (byte_s1 == cfg.param_separator) begin
					sep_q <= sep_q + POS_W'(1);
				end
				pos_q <= pos_q + POS_W'(1);
			end
		end
	end

	always_comb begin
		code             = marker_q ? lookup_cmd(letter1_q, letter2_q) : CMD_UNKNOWN;
		res.frame_length = to_len(pos_q);
		res.overflowed   = ovf_q;
		res.is_command   = marker_q;
		res.command_code = code;
		res.param_count  = to_len(sep_q);
		res.first_param  = acc_q;
		case (code)
			CMD_HI:  res.reply_code = REPLY_HI;
			CMD_BY:  res.reply_code = REPLY_BYE;
			default: res.reply_code = REPLY_NONE;
		endcase
	end

endmodule

`default_nettype wire
